// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the multiply/divide unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/imdu_pkg.sv
// ----------------------------------------------------------------------------
// imdu_pkg
// Types and constants of the 64-bit multiply/divide unit.
// ----------------------------------------------------------------------------
package imdu_pkg;

	localparam int unsigned Width = 64;

	// Operation codes.
	localparam logic [2:0] MODE_MULU = 3'd0;
	localparam logic [2:0] MODE_DIVU = 3'd1;
	localparam logic [2:0] MODE_DIVS = 3'd2;
	localparam logic [2:0] MODE_REMU = 3'd3;
	localparam logic [2:0] MODE_REMS = 3'd4;

	// Word carried from cell to cell along the chain.
	typedef struct packed {
		logic             vld;
		logic             is_mul;
		logic             is_rem;
		logic             neg_q;
		logic             neg_r;
		logic             dz;
		logic             zero_out;
		logic [Width-1:0] x;
		logic [Width-1:0] y;
		logic [Width-1:0] acc;
		logic [Width-1:0] rem;
	} imdu_word_t;

endpackage

// File: rtl/core/imdu_cell.sv
// ----------------------------------------------------------------------------
// imdu_cell
// One chain cell: a shift-add multiply step or a restoring divide step.
// ----------------------------------------------------------------------------
module imdu_cell
	import imdu_pkg::*;
#(
	parameter int unsigned BIT_IDX = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  imdu_word_t din,
	output imdu_word_t dout
);

	localparam int unsigned MulSh = Width - 1 - BIT_IDX;

	imdu_word_t       nxt;
	imdu_word_t       word_q;
	logic             vld_q;
	logic [Width:0]   trial;
	logic [Width:0]   rsh;

	// Multiply consumes one multiplier bit from the LSB up; divide takes one
	// dividend bit from the MSB down into the partial remainder. The shifted
	// remainder keeps its top bit, since the divisor may use all 64 bits.
	always_comb begin
		nxt = din;
		rsh = {din.rem, din.x[BIT_IDX]};
		trial = rsh - {1'b0, din.y};
		if (din.is_mul) begin
			if (din.y[MulSh])
				nxt.acc = din.acc + (din.x << MulSh);
		end else begin
			nxt.rem = trial[Width] ? rsh[Width-1:0] : trial[Width-1:0];
			nxt.acc[BIT_IDX] = ~trial[Width];
		end
	end

	// Control bit is reset; payload is not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= nxt;
		end
	end

	// Outgoing word with the reset valid bit in place.
	always_comb begin
		dout = word_q;
		dout.vld = vld_q;
	end

endmodule

// File: rtl/core/int64_mul_div_unit.sv
// ----------------------------------------------------------------------------
// int64_mul_div_unit
// 64-bit multiply, divide and remainder over a chain of 64 bit cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Words
// in       in         mode, a_high, a_low, b_high, b_low
// out      out        result_high, result_low, divide_by_zero
//
// One word is accepted every cycle when the output side keeps pace.
// A word passes one input stage, 64 cells and the output register,
// which takes the sign fix-up from the last cell directly. The chain
// advances as a whole; it stalls whenever the output register holds an
// untaken word, even when bubbles sit in the chain.
// Reset clears all valid bits; no clearing pass is needed.
`include "assert_macros.svh"
module int64_mul_div_unit
	import imdu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [31:0] a_high,
	input  logic [31:0] a_low,
	input  logic [31:0] b_high,
	input  logic [31:0] b_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_high,
	output logic [31:0] result_low,
	output logic        divide_by_zero
);

	imdu_word_t chain [0:Width];
	imdu_word_t head;
	imdu_word_t in_word_q;
	imdu_word_t in_word;
	logic       in_vld_q;
	logic       adv;
	logic [Width-1:0] a_w, b_w, r_w;
	logic [Width-1:0] res_q;
	logic             dz_q;

	assign a_w = {a_high, a_low};
	assign b_w = {b_high, b_low};

	// The chain moves when the output register is free or being emptied.
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Operand decode: signed modes work on magnitudes.
	always_comb begin
		logic sgn;
		logic div;
		sgn = (mode == MODE_DIVS) || (mode == MODE_REMS);
		div = (mode == MODE_DIVU) || (mode == MODE_DIVS) ||
			(mode == MODE_REMU) || (mode == MODE_REMS);
		head = '0;
		head.vld      = in_valid;
		head.is_mul   = (mode == MODE_MULU);
		head.is_rem   = (mode == MODE_REMU) || (mode == MODE_REMS);
		head.dz       = div && (b_w == '0);
		head.zero_out = !div && (mode != MODE_MULU);
		head.neg_q    = sgn && (a_w[Width-1] ^ b_w[Width-1]);
		head.neg_r    = sgn && a_w[Width-1];
		head.x = (sgn && a_w[Width-1]) ? (~a_w + 1'b1) : a_w;
		head.y = (sgn && b_w[Width-1]) ? (~b_w + 1'b1) : b_w;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_q <= 1'b0;
		end else if (adv) begin
			in_vld_q <= head.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_word_q <= head;
		end
	end

	always_comb begin
		in_word = in_word_q;
		in_word.vld = in_vld_q;
	end

	assign chain[0] = in_word;

	// Row of cells, one per operand bit.
	for (genvar i = 0; i < Width; i++) begin : g_cell
		imdu_cell #(
			.BIT_IDX(Width - 1 - i)
		) u_cell (
			.clk (clk),
			.arst_n (arst_n),
			.en  (adv),
			.din (chain[i]),
			.dout(chain[i+1])
		);
	end

	// Result selection and sign fix-up.
	always_comb begin
		imdu_word_t t;
		t = chain[Width];
		if (t.is_mul)
			r_w = t.acc;
		else if (t.is_rem)
			r_w = t.neg_r ? (~t.rem + 1'b1) : t.rem;
		else
			r_w = t.neg_q ? (~t.acc + 1'b1) : t.acc;
		if (t.dz || t.zero_out)
			r_w = '0;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= chain[Width].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= r_w;
			dz_q  <= chain[Width].dz;
		end
	end

	assign result_high    = res_q[Width-1:Width/2];
	assign result_low     = res_q[Width/2-1:0];
	assign divide_by_zero = dz_q;

	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_low), "result changed while stalled")
	`CHK_IMPL(a_dz_zero, clk, arst_n, out_valid && divide_by_zero, result_high == '0 && result_low == '0, "divide by zero gave nonzero result")
	`CHK_NEXT(a_flow, clk, arst_n, adv && chain[Width].vld, out_valid, "word lost at chain end")

endmodule
